>>> design/rpps_pkg.sv
// Shared types and constants for the rounded panel pixel shader.
package rpps_pkg;

	localparam int unsigned COORD_W   = 8;
	localparam int unsigned SIDE_W    = 9;
	localparam int unsigned RADIUS_W  = 8;
	localparam int unsigned COLOR_W   = 24;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned HALF_W    = 9;   // half-pixel coordinate / radius
	localparam int unsigned GEO_W     = 12;  // signed half-pixel geometry
	localparam int unsigned DELTA_W   = 11;  // corner offset magnitude
	localparam int unsigned EDGE_W    = 11;  // signed edge distance
	localparam int unsigned DIST_W    = 2 * DELTA_W;
	localparam int unsigned RSQ_W     = 2 * HALF_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIDE   = 2'd0,
		REG_RADIUS = 2'd1,
		REG_FILL   = 2'd2,
		REG_FRAME  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FR_FILL  = 2'd0,
		FR_DARK  = 2'd1,
		FR_LIGHT = 2'd2
	} frame_class_t;

	localparam logic [SIDE_W-1:0]   SIDE_RST   = 9'd256;
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 8'd28;
	localparam logic [COLOR_W-1:0]  FILL_RST   = 24'hF3EEE2;

	localparam logic [COLOR_W-1:0]  DARK_GOLD  = 24'hC8AA6E;
	localparam logic [COLOR_W-1:0]  LIGHT_GOLD = 24'hFFF6DF;

	localparam logic [CHAN_W-1:0]   ALPHA_ON   = 8'hFF;
	localparam logic [CHAN_W-1:0]   ALPHA_OFF  = 8'h00;

	typedef struct packed {
		logic                corner;
		logic [DELTA_W-1:0]  dx;
		logic [DELTA_W-1:0]  dy;
		logic [HALF_W-1:0]   rad;
		frame_class_t        fclass;
	} geom_t;

endpackage

>>> design/rpps_if.sv
// Valid/ready channel interfaces for pixel coordinates and BGRA colors.
interface rpps_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_x;
	logic [7:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rpps_rgba_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	logic [7:0] alpha;

	modport source (output valid, output blue, output green, output red, output alpha,
		input ready);
	modport sink   (input valid, input blue, input green, input red, input alpha,
		output ready);
endinterface

>>> design/rpps_geom.sv
// Corner region selection, corner offsets and frame band class for one pixel.
module rpps_geom
	import rpps_pkg::*;
(
	input  logic [COORD_W-1:0]  x,
	input  logic [COORD_W-1:0]  y,
	input  logic [SIDE_W-1:0]   side,
	input  logic [RADIUS_W-1:0] radius,
	output geom_t               geom
);

	logic [HALF_W-1:0]        px, py, rad;
	logic signed [GEO_W-1:0]  px_s, py_s, rad_s, far_s;
	logic signed [GEO_W-1:0]  dx_l, dx_r, dy_t, dy_b;
	logic                     left, right, top, bottom;
	logic signed [EDGE_W-1:0] side_m1, ex0, ex1, ey0, ey1, ex, ey, e;

	assign px    = {x, 1'b1};
	assign py    = {y, 1'b1};
	assign rad   = {radius, 1'b0};
	assign px_s  = $signed({3'b0, px});
	assign py_s  = $signed({3'b0, py});
	assign rad_s = $signed({3'b0, rad});
	assign far_s = $signed({2'b0, side, 1'b0}) - rad_s;

	assign left   = px_s < rad_s;
	assign top    = py_s < rad_s;
	assign right  = px_s > far_s;
	assign bottom = py_s > far_s;

	assign dx_l = rad_s - px_s;
	assign dx_r = px_s - far_s;
	assign dy_t = rad_s - py_s;
	assign dy_b = py_s - far_s;

	assign side_m1 = $signed({2'b0, side}) - 11'sd1;
	assign ex0 = $signed({3'b0, x});
	assign ey0 = $signed({3'b0, y});
	assign ex1 = side_m1 - ex0;
	assign ey1 = side_m1 - ey0;
	assign ex  = (ex0 < ex1) ? ex0 : ex1;
	assign ey  = (ey0 < ey1) ? ey0 : ey1;
	assign e   = (ex < ey) ? ex : ey;

	always_comb begin
		geom.rad    = rad;
		geom.corner = 1'b1;
		geom.dx     = '0;
		geom.dy     = '0;
		// first matching corner wins when regions overlap
		if (left && top) begin
			geom.dx = dx_l[DELTA_W-1:0];
			geom.dy = dy_t[DELTA_W-1:0];
		end else if (right && top) begin
			geom.dx = dx_r[DELTA_W-1:0];
			geom.dy = dy_t[DELTA_W-1:0];
		end else if (left && bottom) begin
			geom.dx = dx_l[DELTA_W-1:0];
			geom.dy = dy_b[DELTA_W-1:0];
		end else if (right && bottom) begin
			geom.dx = dx_r[DELTA_W-1:0];
			geom.dy = dy_b[DELTA_W-1:0];
		end else begin
			geom.corner = 1'b0;
		end

		if (e <= 11'sd2)
			geom.fclass = FR_DARK;
		else if (e == 11'sd4 || e == 11'sd5)
			geom.fclass = FR_LIGHT;
		else
			geom.fclass = FR_FILL;
	end

endmodule

>>> design/rounded_panel_pixel_shader.sv
// Top level of the rounded panel pixel shader.
//
// Usage: pixel coordinates (pixel_x, pixel_y) arrive on the pixel channel and
// one BGRA color per coordinate leaves on the color channel, in order. Alpha is
// 255 inside the rounded square and 0 outside; an outside pixel carries the
// fill color. With the frame enabled, inside pixels near the edge turn gold.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) taken
// at any clock edge with cfg_we high; write it only while no pixel is in flight.
// A result passes from its coordinate transfer through the stage 1 register
// into the output register, where it is offered to the receiver.
// Throughput: one pixel per clock while the receiver takes results; stage 1
// registers corner offsets and frame class, stage 2 squares the offsets,
// compares and registers the color. On a receiver stall the result holds in
// the output register, stage 1 fills if empty and then pixel.ready drops.
// Reset clears both valid bits and loads the register reset values
// (side 256, radius 28, fill F3EEE2, frame on).
module rounded_panel_pixel_shader
	import rpps_pkg::*;
#(
	parameter int MAX_SIDE = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data,
	rpps_pix_if.sink             pixel,
	rpps_rgba_if.source          color
);

	logic [SIDE_W-1:0]   side_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [COLOR_W-1:0]  fill_q;
	logic                frame_q;

	logic [SIDE_W-1:0]   side_eff;
	geom_t               geom, geom_s1;
	logic                valid_s1, valid_s2;
	logic                adv;

	logic [DIST_W-1:0]   dx_sq, dy_sq, dist_sq;
	logic [RSQ_W-1:0]    rad_sq;
	logic                in_shape;
	logic [COLOR_W-1:0]  rgb;
	logic [CHAN_W-1:0]   blue_s2, green_s2, red_s2, alpha_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q   <= SIDE_RST;
			radius_q <= RADIUS_RST;
			fill_q   <= FILL_RST;
			frame_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SIDE:   side_q   <= cfg_data[SIDE_W-1:0];
				REG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				REG_FILL:   fill_q   <= cfg_data;
				REG_FRAME:  frame_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(side_q) > MAX_SIDE)
			side_eff = SIDE_W'(MAX_SIDE);
		else
			side_eff = side_q;
	end

	rpps_geom u_geom (
		.x      (pixel.pixel_x),
		.y      (pixel.pixel_y),
		.side   (side_eff),
		.radius (radius_q),
		.geom   (geom)
	);

	assign adv         = !valid_s2 || color.ready;
	assign pixel.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pixel.ready)
				valid_s1 <= pixel.valid;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.ready && pixel.valid)
			geom_s1 <= geom;
	end

	// exact squared distance to the corner circle center
	assign dx_sq    = geom_s1.dx * geom_s1.dx;
	assign dy_sq    = geom_s1.dy * geom_s1.dy;
	assign dist_sq  = dx_sq + dy_sq;
	assign rad_sq   = geom_s1.rad * geom_s1.rad;
	assign in_shape = !geom_s1.corner || (dist_sq <= DIST_W'(rad_sq));

	always_comb begin
		rgb = fill_q;
		if (in_shape && frame_q) begin
			case (geom_s1.fclass)
				FR_DARK:  rgb = DARK_GOLD;
				FR_LIGHT: rgb = LIGHT_GOLD;
				default:  rgb = fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			blue_s2  <= rgb[7:0];
			green_s2 <= rgb[15:8];
			red_s2   <= rgb[23:16];
			alpha_s2 <= in_shape ? ALPHA_ON : ALPHA_OFF;
		end
	end

	assign color.valid = valid_s2;
	assign color.blue  = blue_s2;
	assign color.green = green_s2;
	assign color.red   = red_s2;
	assign color.alpha = alpha_s2;

endmodule

>>> design/rpps_check.sv
// Port-level assertions for the rounded panel pixel shader, bound to the top level.
module rpps_check (
	input logic       clk,
	input logic       arst_n,
	input logic       pixel_valid,
	input logic       pixel_ready,
	input logic       color_valid,
	input logic       color_ready,
	input logic [7:0] color_alpha
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid && !color_ready |=> color_valid)
		else $error("color result dropped while stalled");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid |-> (color_alpha == 8'hFF || color_alpha == 8'h00))
		else $error("alpha neither opaque nor clear");

	// result offered after a transfer when the receiver keeps taking
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel_ready) ##1 color_ready |=> color_valid)
		else $error("result missing two cycles after transfer");

	// input stalls only behind a blocked output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> (color_valid && !color_ready))
		else $error("pixel input stalled without output backpressure");

	a_reset: assert property (@(posedge clk)
		!arst_n |=> !color_valid)
		else $error("color valid during reset");

endmodule

bind rounded_panel_pixel_shader rpps_check u_rpps_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel.valid),
	.pixel_ready (pixel.ready),
	.color_valid (color.valid),
	.color_ready (color.ready),
	.color_alpha (color.alpha)
);
